// File: rtl/usr_pkg.sv
package usr_pkg;

	localparam int BUF_DEPTH = 6;
	localparam int REPL_W = 31;
	localparam logic [REPL_W-1:0] REPL_RESET = 31'd63;

	typedef logic [BUF_DEPTH-1:0][7:0] pend_arr_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       string_done;
		logic       last_of_run;
	} result_t;

	typedef enum logic [1:0] {
		J_WAIT,
		J_GOOD,
		J_BAD
	} jstat_t;

	typedef struct packed {
		jstat_t     status;
		logic [2:0] used;
	} judge_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_GOOD,
		ST_REPL
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_good;
		logic load_repl;
		logic emit_good;
		logic emit_repl;
	} cmd_t;

	typedef struct packed {
		jstat_t cur;
		logic   grp_end;
		logic   step_end;
		logic   slot_free;
	} stat_t;

	// Encoded length of a code point, 1..6 bytes.
	function automatic logic [2:0] enc_len(logic [REPL_W-1:0] c);
		logic [2:0] n;
		if (c <= 31'h7f) n = 3'd1;
		else if (c <= 31'h7ff) n = 3'd2;
		else if (c <= 31'hffff) n = 3'd3;
		else if (c <= 31'h1fffff) n = 3'd4;
		else if (c <= 31'h3ffffff) n = 3'd5;
		else n = 3'd6;
		return n;
	endfunction

	// Six-bit chunk k of a code point, chunk 0 least significant.
	function automatic logic [5:0] chunk(logic [REPL_W-1:0] c, logic [2:0] k);
		logic [5:0] r;
		case (k)
			3'd0: r = c[5:0];
			3'd1: r = c[11:6];
			3'd2: r = c[17:12];
			3'd3: r = c[23:18];
			3'd4: r = c[29:24];
			default: r = {5'd0, c[30]};
		endcase
		return r;
	endfunction

	function automatic logic [7:0] lead_prefix(logic [2:0] n);
		logic [7:0] p;
		case (n)
			3'd2: p = 8'hc0;
			3'd3: p = 8'he0;
			3'd4: p = 8'hf0;
			3'd5: p = 8'hf8;
			3'd6: p = 8'hfc;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

	// left counts the bytes still to send, including this one.
	function automatic logic [7:0] repl_byte(logic [REPL_W-1:0] c, logic [2:0] n,
			logic [2:0] left);
		logic [7:0] r;
		logic [5:0] ch;
		ch = chunk(c, left - 3'd1);
		if (n == 3'd1) r = {1'b0, c[6:0]};
		else if (left == n) r = lead_prefix(n) | {2'b00, ch};
		else r = {2'b10, ch};
		return r;
	endfunction

	// Decide the sequence at the head of the buffer.
	function automatic judge_t judge(pend_arr_t b, logic [2:0] avail, logic fin);
		judge_t r;
		logic [2:0] n;
		logic bad_lead;
		logic bad_cont;
		logic over;
		r.status = J_WAIT;
		r.used = 3'd1;
		n = 3'd1;
		bad_lead = 1'b0;
		bad_cont = 1'b0;
		over = 1'b0;
		if (b[0][7:5] == 3'b110) n = 3'd2;
		else if (b[0][7:4] == 4'b1110) n = 3'd3;
		else if (b[0][7:3] == 5'b11110) n = 3'd4;
		else if (b[0][7:2] == 6'b111110) n = 3'd5;
		else if (b[0][7:1] == 7'b1111110) n = 3'd6;
		else bad_lead = 1'b1;
		for (int i = 1; i < BUF_DEPTH; i++) begin
			if (3'(i) < n && 3'(i) < avail && b[i][7:6] != 2'b10) bad_cont = 1'b1;
		end
		// overlong: the payload fits in a shorter form
		case (n)
			3'd2: over = (b[0][4:1] == 4'd0);
			3'd3: over = (b[0][3:0] == 4'd0) && !b[1][5];
			3'd4: over = (b[0][2:0] == 3'd0) && (b[1][5:4] == 2'd0);
			3'd5: over = (b[0][1:0] == 2'd0) && (b[1][5:3] == 3'd0);
			3'd6: over = !b[0][0] && (b[1][5:2] == 4'd0);
			default: over = 1'b0;
		endcase
		if (avail == 3'd0) r.status = J_WAIT;
		else if (!b[0][7]) r.status = J_GOOD;
		else if (bad_lead || bad_cont) r.status = J_BAD;
		else if (avail < n) r.status = fin ? J_BAD : J_WAIT;
		else if (over) r.status = J_BAD;
		else begin
			r.status = J_GOOD;
			r.used = n;
		end
		return r;
	endfunction

endpackage

// File: rtl/usr_ctrl.sv
module usr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  usr_pkg::stat_t stat,
	output usr_pkg::cmd_t  cmd
);
	import usr_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		item_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_nx = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				case (stat.cur)
					J_GOOD: begin
						cmd.load_good = 1'b1;
						state_nx = ST_GOOD;
					end
					J_BAD: begin
						cmd.load_repl = 1'b1;
						state_nx = ST_REPL;
					end
					default: state_nx = ST_IDLE;
				endcase
			end
			ST_GOOD: begin
				if (stat.slot_free) begin
					cmd.emit_good = 1'b1;
					if (stat.grp_end) state_nx = stat.step_end ? ST_IDLE : ST_DECIDE;
				end
			end
			ST_REPL: begin
				if (stat.slot_free) begin
					cmd.emit_repl = 1'b1;
					if (stat.grp_end) state_nx = stat.step_end ? ST_IDLE : ST_DECIDE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/usr_dpath.sv
module usr_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  usr_pkg::item_t                item,
	input  logic                          cfg_we,
	input  logic [usr_pkg::REPL_W-1:0]    cfg_data,
	input  usr_pkg::cmd_t                 cmd,
	output usr_pkg::stat_t                stat,
	output logic                          res_valid,
	input  logic                          res_stall,
	output usr_pkg::result_t              res
);
	import usr_pkg::*;

	pend_arr_t         pend_q;
	logic [2:0]        cnt_q;
	logic              eos_q;
	logic [2:0]        left_q;
	logic [REPL_W-1:0] repl_q;
	result_t           res_q;
	logic              res_valid_q;

	pend_arr_t  sh;
	judge_t     cur;
	judge_t     look;
	logic [2:0] repl_len;
	logic       grp_end;
	logic       last;
	logic       shift;
	logic       emit;

	// sh is the buffer once the head byte is gone
	assign sh       = pend_arr_t'(pend_q >> 8);
	assign cur      = judge(pend_q, cnt_q, eos_q);
	assign look     = judge(sh, cnt_q - 3'd1, eos_q);
	assign repl_len = enc_len(repl_q);
	assign grp_end  = (left_q == 3'd1);
	assign last     = grp_end && (look.status == J_WAIT);
	assign shift    = cmd.emit_good || (cmd.emit_repl && grp_end);
	assign emit     = cmd.emit_good || cmd.emit_repl;

	assign stat.cur       = cur.status;
	assign stat.grp_end   = grp_end;
	assign stat.step_end  = last;
	assign stat.slot_free = !res_valid_q || !res_stall;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			for (int i = 0; i < BUF_DEPTH; i++) begin
				if (3'(i) == cnt_q) pend_q[i] <= item.data_byte;
			end
			eos_q <= item.end_of_string;
		end else if (shift) begin
			pend_q <= sh;
		end
		if (emit) begin
			res_q.out_byte    <= cmd.emit_good ? pend_q[0] : repl_byte(repl_q, repl_len, left_q);
			res_q.string_done <= last && eos_q;
			res_q.last_of_run <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= 3'd0;
			left_q      <= 3'd0;
			repl_q      <= REPL_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) cnt_q <= cnt_q + 3'd1;
			else if (shift) cnt_q <= cnt_q - 3'd1;
			if (cmd.load_good) left_q <= cur.used;
			else if (cmd.load_repl) left_q <= repl_len;
			else if (emit) left_q <= left_q - 3'd1;
			if (cfg_we) repl_q <= cfg_data;
			if (emit) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!res_valid_q || !res_stall))
		else $error("result emitted over an untaken result");
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (cnt_q != 3'd0 && left_q != 3'd0))
		else $error("result emitted from an empty buffer or group");
	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> (cnt_q < 3'(BUF_DEPTH)))
		else $error("byte accepted into a full buffer");
	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last && eos_q) |=> (cnt_q == 3'd0))
		else $error("buffer not empty after end of string");
`endif

endmodule

// File: rtl/utf8_stream_repair.sv
// Each input byte is taken in the idle state and judged in the decide state; a byte
// that is only buffered returns to idle, and otherwise each result byte is formed in
// the output register once that register is free. After a group ends, the next group
// is judged in the decide state unless the step is over, and no new byte is taken
// until the state machine is idle again. Reset clears the buffer count, the group byte
// count, the state machine and output valid, and sets the replacement code point to 63.
module utf8_stream_repair (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  usr_pkg::item_t             item,
	output logic                       res_valid,
	input  logic                       res_stall,
	output usr_pkg::result_t           res,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [usr_pkg::REPL_W-1:0] cfg_data
);
	import usr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	usr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	usr_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
